/* hdl/grs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package grs_pkg;

  localparam int MaxGroupDef = 16;
  localparam int DataW       = 32;
  localparam int CfgW        = 5;

  typedef enum logic {
    StIdle,
    StEmit
  } grs_state_e;

  typedef enum logic {
    ModeRev,
    ModeFwd
  } grs_mode_e;

  // chain command: push shifts toward the tail, pop shifts toward the head
  typedef struct packed {
    logic push;
    logic pop;
  } grs_shift_t;

endpackage

`default_nettype wire

/* hdl/group_reverse_stream.sv */
// group_reverse_stream
// Input channel: value_i / end_of_stream_i with valid_i, stall_o. Output
// channel: out_value_o / run_last_o / stream_done_o with valid_o, stall_i.
// A beat moves on an edge with valid high and stall low. group_size_i is
// written by group_size_we_i, which the user must do only while the block is
// idle, which the block does not enforce; 0 acts as 1, above MaxGroup as MaxGroup.
// Values enter a row of MaxGroup cells. A completed group is popped from
// the head of the row, newest first; a partial group closed by end of
// stream is read oldest first through a tap select on the row.
// An input beat that causes no result is taken straight into the row. A
// beat that closes a group of n values stalls the input while the group
// is read out one beat per cycle into the output register, as long as the
// output is not stalled. The closing beat moves the control into its emit
// state, which loads the first result into the output register. A full
// group thus holds the block while the row fills and again while it drains.
// A stalled output holds its beat and pauses draining; no data is lost.
// Reset empties the group, clears the output valid, run_last and stream_done flags and sets group size to 1.
`timescale 1ns / 1ps
`default_nettype none

module group_reverse_stream #(
  parameter int MaxGroup = grs_pkg::MaxGroupDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic signed [grs_pkg::DataW-1:0]  value_i,
  input  wire logic                              end_of_stream_i,
  input  wire logic                              valid_i,
  output logic                                   stall_o,
  input  wire logic                              group_size_we_i,
  input  wire logic [grs_pkg::CfgW-1:0]          group_size_i,
  output logic signed [grs_pkg::DataW-1:0]       out_value_o,
  output logic                                   run_last_o,
  output logic                                   stream_done_o,
  output logic                                   valid_o,
  input  wire logic                              stall_i
);
  import grs_pkg::*;

  localparam int IW = (MaxGroup > 1) ? $clog2(MaxGroup) : 1;

  grs_shift_t              shift;
  logic [IW-1:0]           tap_idx;
  logic signed [DataW-1:0] tap;
  logic signed [DataW-1:0] cell_val [MaxGroup];

  grs_ctrl #(
    .MaxGroup(MaxGroup)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .end_of_stream_i(end_of_stream_i),
    .stall_o        (stall_o),
    .group_size_we_i(group_size_we_i),
    .group_size_i   (group_size_i),
    .shift_o        (shift),
    .tap_idx_o      (tap_idx),
    .tap_i          (tap),
    .out_value_o    (out_value_o),
    .run_last_o     (run_last_o),
    .stream_done_o  (stream_done_o),
    .valid_o        (valid_o),
    .stall_i        (stall_i)
  );

  for (genvar i = 0; i < MaxGroup; i++) begin : g_cell
    logic signed [DataW-1:0] left;
    logic signed [DataW-1:0] right;

    if (i == 0) begin : g_head
      assign left = value_i;
    end else begin : g_body
      assign left = cell_val[i-1];
    end

    if (i == MaxGroup - 1) begin : g_tail
      assign right = cell_val[i];
    end else begin : g_mid
      assign right = cell_val[i+1];
    end

    grs_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .left_i (left),
      .right_i(right),
      .val_o  (cell_val[i])
    );
  end

  assign tap = cell_val[tap_idx];

endmodule

`default_nettype wire

/* hdl/grs_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module grs_cell (
  input  wire logic                                 clk_i,
  input  wire grs_pkg::grs_shift_t                  shift_i,
  input  wire logic signed [grs_pkg::DataW-1:0]     left_i,
  input  wire logic signed [grs_pkg::DataW-1:0]     right_i,
  output logic signed [grs_pkg::DataW-1:0]          val_o
);
  import grs_pkg::*;

  logic signed [DataW-1:0] val_q;
  logic signed [DataW-1:0] val_d;

  always_comb begin
    val_d = val_q;
    if (shift_i.push) begin
      val_d = left_i;
    end else if (shift_i.pop) begin
      val_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

/* hdl/grs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module grs_ctrl #(
  parameter int MaxGroup = grs_pkg::MaxGroupDef,
  localparam int IW = (MaxGroup > 1) ? $clog2(MaxGroup) : 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  input  wire logic                                end_of_stream_i,
  output logic                                     stall_o,
  input  wire logic                                group_size_we_i,
  input  wire logic [grs_pkg::CfgW-1:0]            group_size_i,
  output grs_pkg::grs_shift_t                      shift_o,
  output logic [IW-1:0]                            tap_idx_o,
  input  wire logic signed [grs_pkg::DataW-1:0]    tap_i,
  output logic signed [grs_pkg::DataW-1:0]         out_value_o,
  output logic                                     run_last_o,
  output logic                                     stream_done_o,
  output logic                                     valid_o,
  input  wire logic                                stall_i
);
  import grs_pkg::*;

  localparam int CW = $clog2(MaxGroup + 1);
  localparam int GW = (CW > CfgW) ? CW : CfgW;

  grs_state_e              state_q, state_d;
  grs_mode_e               mode_q, mode_d;
  logic [CW-1:0]           fill_q, fill_d;
  logic [CW-1:0]           rem_q, rem_d;
  logic                    eos_q, eos_d;
  logic [CfgW-1:0]         gsize_q, gsize_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_last_q, out_last_d;
  logic                    out_done_q, out_done_d;
  logic signed [DataW-1:0] out_value_q, out_value_d;

  logic          in_acc;
  logic          out_free;
  logic [CW-1:0] n_cnt;
  logic [GW-1:0] g_eff;
  logic [GW-1:0] cfg_ext;
  logic          last_beat;

  assign in_acc   = valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !stall_i;
  assign n_cnt    = fill_q + CW'(1);
  assign cfg_ext  = GW'(gsize_q);
  assign last_beat = (rem_q == CW'(1));

  always_comb begin
    g_eff = cfg_ext;
    if (cfg_ext == '0) begin
      g_eff = GW'(1);
    end else if (cfg_ext > GW'(MaxGroup)) begin
      g_eff = GW'(MaxGroup);
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    fill_d      = fill_q;
    rem_d       = rem_q;
    eos_d       = eos_q;
    gsize_d     = gsize_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    out_value_d = out_value_q;
    shift_o     = '0;
    tap_idx_o   = '0;

    if (group_size_we_i) begin
      gsize_d = group_size_i;
    end

    if (out_valid_q && !stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          shift_o.push = 1'b1;
          eos_d        = end_of_stream_i;
          if (GW'(n_cnt) >= g_eff) begin
            state_d = StEmit;
            mode_d  = ModeRev;
            rem_d   = n_cnt;
            fill_d  = '0;
          end else if (end_of_stream_i) begin
            state_d = StEmit;
            mode_d  = ModeFwd;
            rem_d   = n_cnt;
            fill_d  = '0;
          end else begin
            fill_d = n_cnt;
          end
        end
      end
      StEmit: begin
        if (mode_q == ModeFwd) begin
          tap_idx_o = IW'(rem_q - CW'(1));
        end
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = tap_i;
          out_last_d  = last_beat;
          out_done_d  = last_beat && eos_q;
          rem_d       = rem_q - CW'(1);
          shift_o.pop = (mode_q == ModeRev);
          if (last_beat) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= ModeRev;
      fill_q      <= '0;
      rem_q       <= '0;
      eos_q       <= 1'b0;
      gsize_q     <= CfgW'(1);
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      fill_q      <= fill_d;
      rem_q       <= rem_d;
      eos_q       <= eos_d;
      gsize_q     <= gsize_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_done_q  <= out_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
  end

  assign stall_o       = (state_q != StIdle);
  assign valid_o       = out_valid_q;
  assign out_value_o   = out_value_q;
  assign run_last_o    = out_last_q;
  assign stream_done_o = out_done_q;

  a_idle_no_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> rem_q == '0)
    else $error("remaining count nonzero while idle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CW'(MaxGroup))
    else $error("fill count reached group buffer depth");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> out_last_q)
    else $error("stream_done without run_last");

  a_shift_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(shift_o.push && shift_o.pop))
    else $error("chain pushed and popped in one cycle");

  a_emit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> rem_q != '0)
    else $error("emitting with no beats left");

endmodule

`default_nettype wire

/* bench/group_reverse_stream_test.sv */
`timescale 1ns / 1ps

module group_reverse_stream_test;
  import grs_pkg::*;

  localparam int QuietCycles = 2 * MaxGroupDef + 8;
  localparam int HoldCycles  = 150;
  localparam int TotalBeats  = 280;
  localparam int CycleLimit  = 200000;
  localparam int MaxPrinted  = 60;

  typedef enum logic [1:0] {
    ItemBeat,
    ItemSize,
    ItemFlush,
    ItemHold
  } feed_kind_e;

  typedef struct {
    feed_kind_e              kind;
    logic signed [DataW-1:0] value;
    logic                    eos;
    logic [CfgW-1:0]         size;
    int unsigned             gap;
  } feed_t;

  typedef struct {
    logic signed [DataW-1:0] value;
    logic                    run_last;
    logic                    stream_done;
  } result_t;

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic signed [DataW-1:0] value_i         = '0;
  logic                    end_of_stream_i = 1'b0;
  logic                    valid_i         = 1'b0;
  logic                    stall_o;
  logic                    group_size_we_i = 1'b0;
  logic [CfgW-1:0]         group_size_i    = '0;
  logic signed [DataW-1:0] out_value_o;
  logic                    run_last_o;
  logic                    stream_done_o;
  logic                    valid_o;
  logic                    stall_i         = 1'b0;

  group_reverse_stream #(
    .MaxGroup(MaxGroupDef)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .end_of_stream_i(end_of_stream_i),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .group_size_we_i(group_size_we_i),
    .group_size_i   (group_size_i),
    .out_value_o    (out_value_o),
    .run_last_o     (run_last_o),
    .stream_done_o  (stream_done_o),
    .valid_o        (valid_o),
    .stall_i        (stall_i)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic signed [DataW-1:0] held [MaxGroupDef];
  int unsigned             fill_cnt = 0;
  logic [CfgW-1:0]         grp_size = 5'd1;
  result_t                 reordered_q [$];

  feed_t       feed_q [$];
  feed_t       cur;
  logic        have_cur  = 1'b0;
  int unsigned gap_left  = 0;
  logic        in_took   = 1'b0;
  logic        hold_kick = 1'b0;
  int unsigned hold_left = 0;
  int unsigned sink_wait = 0;
  logic        sink_calm = 1'b0;
  logic        src_calm  = 1'b0;
  int unsigned quiet     = 0;
  int unsigned cycles    = 0;

  int unsigned queued_beats = 0;
  int unsigned beats_in     = 0;
  int unsigned beats_out    = 0;
  int unsigned streams      = 0;
  int unsigned size_writes  = 0;
  int unsigned errs         = 0;

  task automatic report(input string msg);
    if (errs < MaxPrinted) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    errs++;
  endtask

  function automatic void regroup(input logic signed [DataW-1:0] v, input logic eos);
    int unsigned g;
    int unsigned n;
    result_t     r;
    g = grp_size;
    if (g == 0) g = 1;
    if (g > MaxGroupDef) g = MaxGroupDef;
    if (fill_cnt >= MaxGroupDef) fill_cnt = MaxGroupDef - 1;
    held[fill_cnt] = v;
    fill_cnt++;
    n = fill_cnt;
    if (n >= g || eos) begin
      for (int unsigned i = 0; i < n; i++) begin
        // full group goes out newest first, a partial tail oldest first
        r.value       = (n >= g) ? held[n - 1 - i] : held[i];
        r.run_last    = (i + 1 == n);
        r.stream_done = (i + 1 == n) && eos;
        reordered_q.push_back(r);
      end
      fill_cnt = 0;
    end
  endfunction

  function automatic int unsigned draw_gap();
    return src_calm ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic push_beat(input logic signed [DataW-1:0] v, input logic eos);
    feed_t f;
    f.kind  = ItemBeat;
    f.value = v;
    f.eos   = eos;
    f.size  = '0;
    f.gap   = draw_gap();
    feed_q.push_back(f);
    queued_beats++;
  endtask

  task automatic push_ctrl(input feed_kind_e kind, input logic [CfgW-1:0] sz);
    feed_t f;
    f.kind  = kind;
    f.value = '0;
    f.eos   = 1'b0;
    f.size  = sz;
    f.gap   = 0;
    feed_q.push_back(f);
  endtask

  // sender
  always @(negedge clk_i) begin : drive
    logic nvalid;
    logic nwe;
    logic nkick;
    if (!rst_ni) begin
      valid_i         <= 1'b0;
      group_size_we_i <= 1'b0;
      hold_kick       <= 1'b0;
    end else begin
      nvalid = valid_i && !in_took;
      nwe    = 1'b0;
      nkick  = 1'b0;
      if (!nvalid) begin
        if (!have_cur && feed_q.size() != 0) begin
          cur      = feed_q.pop_front();
          have_cur = 1'b1;
          gap_left = cur.gap;
        end
        if (have_cur) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            case (cur.kind)
              ItemBeat: begin
                value_i         <= cur.value;
                end_of_stream_i <= cur.eos;
                nvalid   = 1'b1;
                have_cur = 1'b0;
              end
              ItemSize: begin
                if (reordered_q.size() == 0 && quiet >= QuietCycles) begin
                  group_size_i <= cur.size;
                  nwe      = 1'b1;
                  grp_size = cur.size;
                  size_writes++;
                  have_cur = 1'b0;
                end
              end
              ItemFlush: begin
                if (reordered_q.size() == 0) have_cur = 1'b0;
              end
              default: begin
                nkick    = 1'b1;
                have_cur = 1'b0;
              end
            endcase
          end
        end
      end
      valid_i         <= nvalid;
      group_size_we_i <= nwe;
      hold_kick       <= nkick;
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else begin
      if (hold_kick) hold_left = HoldCycles;
      if (hold_left != 0) begin
        hold_left--;
        stall_i <= 1'b1;
      end else if (sink_wait != 0) begin
        sink_wait--;
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // monitor: predicts on input beats, checks output beats
  always @(posedge clk_i) begin : watch
    result_t want;
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= valid_i && !stall_o;
      if (reordered_q.size() != 0) quiet = 0;
      else quiet++;
      if (valid_o && !stall_i) begin
        beats_out++;
        quiet = 0;
        if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
        sink_wait = sink_calm ? 0 : $urandom_range(0, 11);
        if (reordered_q.size() == 0) begin
          report($sformatf("unexpected beat value %0d", out_value_o));
        end else begin
          want = reordered_q.pop_front();
          if (out_value_o !== want.value)
            report($sformatf("out_value got %0d want %0d", out_value_o, want.value));
          if (run_last_o !== want.run_last)
            report($sformatf("run_last got %b want %b", run_last_o, want.run_last));
          if (stream_done_o !== want.stream_done)
            report($sformatf("stream_done got %b want %b", stream_done_o,
                             want.stream_done));
        end
      end
      if (valid_i && !stall_o) begin
        regroup(value_i, end_of_stream_i);
        beats_in++;
        if (end_of_stream_i) streams++;
        quiet = 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycles,
               reordered_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stim
    int unsigned     phase;
    int unsigned     len;
    int unsigned     nstreams;
    int unsigned     g;
    int unsigned     pick;
    logic [CfgW-1:0] sz;
    logic            open_end;
    logic signed [DataW-1:0] v;

    // size 1 after reset: pass-through, value extremes
    push_beat(32'sh7fffffff, 1'b0);
    push_beat(32'sh80000000, 1'b1);
    push_beat(-32'sd1, 1'b0);
    // full group reversed, then partial tail in order
    push_ctrl(ItemSize, 5'd4);
    for (int k = 1; k <= 4; k++) push_beat(k, 1'b0);
    push_beat(5, 1'b0);
    push_beat(6, 1'b1);
    // end of stream closing a full group
    push_ctrl(ItemSize, 5'd3);
    push_beat(0, 1'b0);
    push_beat(-32'sd1, 1'b0);
    push_beat(32'sh80000000, 1'b1);
    // zero acts as one
    push_ctrl(ItemSize, 5'd0);
    push_beat(10, 1'b0);
    push_beat(11, 1'b1);
    // oversize clamps; short stream passes through
    push_ctrl(ItemSize, 5'd31);
    push_beat(20, 1'b0);
    push_beat(21, 1'b0);
    push_beat(22, 1'b1);
    // shrink size mid-group
    push_ctrl(ItemSize, 5'd8);
    for (int k = 0; k < 5; k++) push_beat(30 + k, 1'b0);
    push_ctrl(ItemSize, 5'd2);
    push_beat(35, 1'b0);

    phase = 0;
    while (queued_beats < TotalBeats) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0:       sz = 5'd1;
        1:       sz = 5'd16;
        2:       sz = 5'd0;
        3:       sz = CfgW'($urandom_range(17, 31));
        default: sz = CfgW'($urandom_range(2, 16));
      endcase
      src_calm = ($urandom_range(0, 2) == 0);
      nstreams = $urandom_range(1, 3);
      if (phase == 1) begin
        // long output stall while input keeps coming back to back
        sz       = 5'd4;
        src_calm = 1'b1;
        nstreams = 1;
      end
      push_ctrl(ItemSize, sz);
      if (phase == 1) push_ctrl(ItemHold, '0);
      g = (sz == 0) ? 1 : (sz > MaxGroupDef) ? MaxGroupDef : sz;
      for (int s = 0; s < nstreams; s++) begin
        len      = (phase == 1) ? 24 : $urandom_range(1, 3 * g);
        if (len > TotalBeats - queued_beats) len = TotalBeats - queued_beats;
        open_end = (s == nstreams - 1) && ($urandom_range(0, 2) == 0) && (phase != 1);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 9))
            0:       v = 32'sh7fffffff;
            1:       v = 32'sh80000000;
            2:       v = 0;
            3:       v = -32'sd1;
            default: v = $urandom;
          endcase
          push_beat(v, (k == len - 1) && !open_end);
        end
        if ($urandom_range(0, 4) == 0) push_ctrl(ItemFlush, '0);
      end
      phase++;
    end

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (feed_q.size() != 0 || have_cur || valid_i) @(posedge clk_i);
    while (reordered_q.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);

    $display("Run covered %0d input beats in %0d streams and %0d checked result beats",
             beats_in, streams, beats_out);
    $display("over %0d group size writes: zero, oversize, 1 to 16, mid-group shrink, stalls",
             size_writes);
    if (errs == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errs);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
